// ----- hdl/shift_jis_to_euc_jp_converter_core_defines.svh -----
// ----------------------------------------------------------------------------
// shift-jis to euc-jp converter: assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SHIFT_JIS_TO_EUC_JP_CONVERTER_CORE_DEFINES_SVH
`define SHIFT_JIS_TO_EUC_JP_CONVERTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every edge out of reset
`define SJE_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SJE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SJE_ASSERT(label, clk_s, rst_s, prop, msg)

`define SJE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg)

`endif

`endif

// ----- hdl/sje_pkg.sv -----
// ----------------------------------------------------------------------------
// sje_pkg
// types, byte constants and helpers shared by the converter modules
// ----------------------------------------------------------------------------
package sje_pkg;

  // byte codes
  localparam logic [7:0] SS2_CODE     = 8'h8e;
  localparam logic [7:0] ASCII_LIMIT  = 8'h80;
  localparam logic [7:0] LEAD1_LO     = 8'h81;
  localparam logic [7:0] LEAD1_HI     = 8'h9f;
  localparam logic [7:0] LEAD2_LO     = 8'he0;
  localparam logic [7:0] LEAD2_HI     = 8'hef;
  localparam logic [7:0] TRAIL_LO     = 8'h40;
  localparam logic [7:0] TRAIL_HI     = 8'hfc;
  localparam logic [7:0] TRAIL_LOW_HI = 8'h9e;
  localparam logic [7:0] TRAIL_GAP    = 8'h7f;
  localparam logic [7:0] ROW1_BASE    = 8'ha1;
  localparam logic [7:0] ROW2_BASE    = 8'hdf;
  localparam logic [7:0] CELL_LOW_ADD  = 8'h61;
  localparam logic [7:0] CELL_HIGH_ADD = 8'h02;

  // default depth of the job queue
  localparam int QUEUE_DEPTH = 2;

  // input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } sje_in_t;

  // output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;
  } sje_out_t;

  // job kinds handed from front to back
  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,  // single byte as is
    KIND_ESC  = 2'd1,  // ss2 then byte
    KIND_PAIR = 2'd2,  // two-byte gr code
    KIND_BAD  = 2'd3   // ss2 lead ss2 trail
  } sje_kind_t;

  typedef struct packed {
    sje_kind_t  kind;
    logic [7:0] lead;
    logic [7:0] data;
    logic       last;
  } sje_job_t;

  // lead byte test
  function automatic logic is_lead(input logic [7:0] b);
    is_lead = ((b >= LEAD1_LO) && (b <= LEAD1_HI)) ||
              ((b >= LEAD2_LO) && (b <= LEAD2_HI));
  endfunction

  // index of the final output byte of a job
  function automatic logic [1:0] last_index(input sje_kind_t kind);
    unique case (kind)
      KIND_PASS: last_index = 2'd0;
      KIND_ESC:  last_index = 2'd1;
      KIND_PAIR: last_index = 2'd1;
      KIND_BAD:  last_index = 2'd3;
      default:   last_index = 2'd0;
    endcase
  endfunction

endpackage

// ----- hdl/shift_jis_to_euc_jp_converter_core.sv -----
// ----------------------------------------------------------------------------
// shift_jis_to_euc_jp_converter_core
// shift-jis byte stream in, euc-jp byte stream out
// ----------------------------------------------------------------------------
// One Shift-JIS byte is taken per up word and one EUC-JP byte leaves per dn
// word, zero to four per input byte, in order. The front end takes a byte
// every cycle while the job queue has room; a lead byte with no lead held
// and no end_of_text only sets the held lead and sends nothing. The back
// end sends one byte per cycle through its output register while dn is not
// stalled: a byte below 0x80 gives one byte, a valid pair or an escaped byte
// two and a pair with a bad trail four. A job waits in the queue and the
// current job register on its way to dn. run_last marks the last byte caused
// by an input word and text_done marks it when that word had end_of_text set.
// QueueDepth sets how many classified jobs may wait between the two ends.
// ----------------------------------------------------------------------------
module shift_jis_to_euc_jp_converter_core #(
  parameter int QueueDepth = sje_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_stall,
  input  sje_pkg::sje_in_t  up_word,
  output logic              dn_valid,
  input  logic              dn_stall,
  output sje_pkg::sje_out_t dn_word
);
  import sje_pkg::*;

  logic     push;
  logic     q_full;
  sje_job_t push_job;
  logic     pop;
  logic     q_valid;
  sje_job_t head;

  // classification
  sje_front u_front (
    .clk      (clk),
    .rst      (rst),
    .up_valid (up_valid),
    .up_stall (up_stall),
    .up_word  (up_word),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  // job queue
  sje_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  // byte output
  sje_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .dn_valid (dn_valid),
    .dn_stall (dn_stall),
    .dn_word  (dn_word)
  );

endmodule

// ----- hdl/sje_front.sv -----
// ----------------------------------------------------------------------------
// sje_front
// accepts input words, holds lead bytes and turns every other word into a job
// ----------------------------------------------------------------------------
`include "shift_jis_to_euc_jp_converter_core_defines.svh"

module sje_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_stall,
  input  sje_pkg::sje_in_t  up_word,
  input  logic              q_full,
  output logic              push,
  output sje_pkg::sje_job_t job
);
  import sje_pkg::*;

  logic       lead_waiting;
  logic       lead_waiting_next;
  logic [7:0] held_lead;
  logic       accept;
  logic       hold;
  logic [7:0] b;

  assign b        = up_word.in_byte;
  assign up_stall = q_full;
  assign accept   = up_valid & ~q_full;

  // a lead byte that does not end the text and follows no held lead is held back
  assign hold = ~lead_waiting & is_lead(b) & ~up_word.end_of_text;
  assign push = accept & ~hold;

  // classify
  always_comb begin
    job.lead = held_lead;
    job.data = b;
    job.last = up_word.end_of_text;
    priority if (lead_waiting) begin
      if ((b < TRAIL_LO) || (b > TRAIL_HI)) begin
        job.kind = KIND_BAD;
      end else begin
        job.kind = KIND_PAIR;
      end
    end else if (b < ASCII_LIMIT) begin
      job.kind = KIND_PASS;
    end else begin
      job.kind = KIND_ESC;
    end
  end

  // lead state
  always_comb begin
    lead_waiting_next = lead_waiting;
    if (accept) begin
      lead_waiting_next = hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_waiting <= 1'b0;
    end else begin
      lead_waiting <= lead_waiting_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold) begin
      held_lead <= b;
    end
  end

  `SJE_ASSERT(a_held_is_lead, clk, rst, !lead_waiting || is_lead(held_lead), "held byte is not a lead byte")
  `SJE_ASSERT_NEXT(a_lead_taken, clk, rst, accept && hold, lead_waiting, "lead byte was not held")

endmodule

// ----- hdl/sje_queue.sv -----
// ----------------------------------------------------------------------------
// sje_queue
// short job queue between the front and back ends
// ----------------------------------------------------------------------------
`include "shift_jis_to_euc_jp_converter_core_defines.svh"

module sje_queue #(
  parameter int Depth = sje_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sje_pkg::sje_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output sje_pkg::sje_job_t head
);
  import sje_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sje_job_t          entries [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic [CntW-1:0]   count_next;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CntW'(Depth));
  assign q_valid = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push & ~full;
  assign do_pop  = pop & q_valid;

  // occupancy
  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (do_pop && !do_push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  `SJE_ASSERT(a_no_overflow, clk, rst, !(push && full), "push into a full queue")
  `SJE_ASSERT(a_count_range, clk, rst, count <= CntW'(Depth), "queue count out of range")

endmodule

// ----- hdl/sje_back.sv -----
// ----------------------------------------------------------------------------
// sje_back
// takes jobs from the queue and sends their euc-jp bytes one word at a time
// ----------------------------------------------------------------------------
`include "shift_jis_to_euc_jp_converter_core_defines.svh"

module sje_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  sje_pkg::sje_job_t head,
  output logic              pop,
  output logic              dn_valid,
  input  logic              dn_stall,
  output sje_pkg::sje_out_t dn_word
);
  import sje_pkg::*;

  sje_job_t   cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic [1:0] cur_last;
  logic       out_free;
  logic       step;
  logic       finish;
  logic       take;
  logic [7:0] lead_off;
  logic [7:0] base;
  logic [7:0] adj;
  logic       low;
  logic [7:0] r1;
  logic [7:0] r2;
  logic [7:0] byte_sel;

  assign cur_last = last_index(cur.kind);
  assign out_free = ~dn_valid | ~dn_stall;
  assign step     = cur_valid & out_free;
  assign finish   = (idx == cur_last);
  assign take     = out_free & (~cur_valid | finish);
  assign pop      = take & q_valid;

  // pair conversion
  always_comb begin
    if (cur.lead <= LEAD1_HI) begin
      lead_off = cur.lead - LEAD1_LO;
      base     = {lead_off[6:0], 1'b0} + ROW1_BASE;
    end else begin
      lead_off = cur.lead - LEAD2_LO;
      base     = {lead_off[6:0], 1'b0} + ROW2_BASE;
    end
    low = (cur.data <= TRAIL_LOW_HI);
    adj = (cur.data > TRAIL_GAP) ? cur.data - 8'd1 : cur.data;
    r1  = base + {7'd0, ~low};
    r2  = low ? adj + CELL_LOW_ADD : cur.data + CELL_HIGH_ADD;
  end

  // byte for the current position
  always_comb begin
    unique case (cur.kind)
      KIND_PASS: byte_sel = cur.data;
      KIND_ESC:  byte_sel = (idx == 2'd0) ? SS2_CODE : cur.data;
      KIND_PAIR: byte_sel = (idx == 2'd0) ? r1 : r2;
      KIND_BAD: begin
        unique case (idx)
          2'd0:    byte_sel = SS2_CODE;
          2'd1:    byte_sel = cur.lead;
          2'd2:    byte_sel = SS2_CODE;
          2'd3:    byte_sel = cur.data;
          default: byte_sel = SS2_CODE;
        endcase
      end
      default:   byte_sel = cur.data;
    endcase
  end

  // current job and position
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (take) begin
        cur_valid <= q_valid;
        idx       <= 2'd0;
      end else if (step) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (out_free) begin
      dn_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      dn_word.out_byte  <= byte_sel;
      dn_word.run_last  <= finish;
      dn_word.text_done <= finish & cur.last;
    end
  end

  `SJE_ASSERT(a_idx_range, clk, rst, !cur_valid || (idx <= cur_last), "byte index past job end")

endmodule

// ----- bench/shift_jis_to_euc_jp_converter_core_tb.sv -----
// ----------------------------------------------------------------------------
// shift_jis_to_euc_jp_converter_core_tb
// self-checking bench for the shift-jis to euc-jp byte stream converter
// ----------------------------------------------------------------------------
// A short table of directed bytes covers the ascii and escape extremes, both
// lead ranges, good and bad trails, the 0x7f trail, a lead taken as a trail
// and the end-of-text cases. Rows whose output bytes are obvious carry them
// typed in; the rest, and a long run of random text built mostly from ascii
// bytes and well-formed pairs, are checked against a converter model kept in
// the bench. Both sides idle at random, the receiver holds off once for a long
// stretch, and the sender drains the block twice along the way.
// ----------------------------------------------------------------------------
module shift_jis_to_euc_jp_converter_core_tb;
  import sje_pkg::*;

  localparam int NUM_DIRECTED = 26;
  localparam int RANDOM_ITEMS = 224;
  localparam int DRAIN_MID    = NUM_DIRECTED + 120;
  localparam int HOLD_AT      = 70;
  localparam int HOLD_CYCLES  = 60;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 200000;

  // one byte of text, with its output bytes when they are typed in
  typedef struct packed {
    logic [7:0] in_byte;
    logic       eot;
    logic       typed;
    logic [2:0] count;
    logic [7:0] r0, r1, r2, r3;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     up_valid;
  logic     up_stall;
  sje_in_t  up_word;
  logic     dn_valid;
  logic     dn_stall;
  sje_out_t dn_word;

  stim_row_t dir_rows [NUM_DIRECTED];
  stim_row_t stim [$];
  stim_row_t plan_q [$];
  sje_out_t  euc_expected [$];

  // converter model state
  logic [7:0] lead_byte = '0;
  logic       lead_open = 1'b0;

  int fail_count    = 0;
  int items_in      = 0;
  int words_out     = 0;
  int text_ends     = 0;
  int stalled_input = 0;
  int cycles        = 0;
  logic calm;

  // no idling on either side inside this window
  assign calm = (items_in >= 110) && (items_in < 170);

  shift_jis_to_euc_jp_converter_core dut (
    .clk      (clk),
    .rst      (rst),
    .up_valid (up_valid),
    .up_stall (up_stall),
    .up_word  (up_word),
    .dn_valid (dn_valid),
    .dn_stall (dn_stall),
    .dn_word  (dn_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void log_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("error: %s", msg);
  endfunction

  // convert one shift-jis byte, returns how many euc-jp bytes it causes
  function automatic int sjis_to_euc(input logic [7:0] b, input logic eot,
                                     output logic [3:0][7:0] conv);
    int base;
    logic [7:0] t;
    conv = '0;
    if (lead_open) begin
      lead_open = 1'b0;
      if (b < TRAIL_LO || b > TRAIL_HI) begin
        conv = {b, SS2_CODE, lead_byte, SS2_CODE};
        lead_byte = '0;
        return 4;
      end
      if (lead_byte <= LEAD1_HI)
        base = 2 * (int'(lead_byte) - int'(LEAD1_LO)) + int'(ROW1_BASE);
      else
        base = 2 * (int'(lead_byte) - int'(LEAD2_LO)) + int'(ROW2_BASE);
      lead_byte = '0;
      if (b <= TRAIL_LOW_HI) begin
        // trails above the 0x7f gap slide down by one
        t = (b > TRAIL_GAP) ? b - 8'd1 : b;
        conv[0] = base[7:0];
        conv[1] = t - TRAIL_LO + ROW1_BASE;
      end else begin
        base = base + 1;
        conv[0] = base[7:0];
        conv[1] = b - TRAIL_LOW_HI - 8'd1 + ROW1_BASE;
      end
      return 2;
    end
    if (b < ASCII_LIMIT) begin
      conv[0] = b;
      return 1;
    end
    if (((b >= LEAD1_LO) && (b <= LEAD1_HI)) || ((b >= LEAD2_LO) && (b <= LEAD2_HI))) begin
      // a lead that ends the text cannot wait for a trail
      if (eot) begin
        conv[0] = SS2_CODE;
        conv[1] = b;
        return 2;
      end
      lead_byte = b;
      lead_open = 1'b1;
      return 0;
    end
    conv[0] = SS2_CODE;
    conv[1] = b;
    return 2;
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    stim_row_t row;
    row = '0;
    row.in_byte = b;
    row.eot = ($urandom_range(0, 19) == 0);
    stim.push_back(row);
  endfunction

  function automatic logic [7:0] any_lead();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(LEAD1_LO, LEAD1_HI));
    return 8'($urandom_range(LEAD2_LO, LEAD2_HI));
  endfunction

  // offer one word and hold it until the block takes it
  task automatic send_word(input stim_row_t row);
    if (!calm && $urandom_range(0, 99) < 9) begin
      up_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    plan_q.push_back(row);
    up_valid <= 1'b1;
    up_word  <= '{in_byte: row.in_byte, end_of_text: row.eot};
    @(posedge clk);
    while (up_stall) @(posedge clk);
  endtask

  // stop sending until every expected word has come out
  task automatic wait_for_drain();
    up_valid <= 1'b0;
    do @(negedge clk); while (euc_expected.size() != 0);
    @(posedge clk);
  endtask

  // check output words and predict the words of each accepted input word
  always @(posedge clk) begin : scoreboard
    sje_out_t want;
    stim_row_t plan;
    logic [3:0][7:0] conv;
    int n;
    if (!rst) begin
      if (dn_valid && !dn_stall) begin
        words_out <= words_out + 1;
        if (euc_expected.size() == 0) begin
          log_fail($sformatf("unexpected word: byte %02h last %0b done %0b",
                             dn_word.out_byte, dn_word.run_last, dn_word.text_done));
        end else begin
          want = euc_expected.pop_front();
          if (dn_word.out_byte !== want.out_byte || dn_word.run_last !== want.run_last ||
              dn_word.text_done !== want.text_done)
            log_fail($sformatf("expected %02h last %0b done %0b, got %02h last %0b done %0b",
                               want.out_byte, want.run_last, want.text_done,
                               dn_word.out_byte, dn_word.run_last, dn_word.text_done));
        end
      end
      if (up_valid && !up_stall) begin
        items_in <= items_in + 1;
        if (up_word.end_of_text) text_ends <= text_ends + 1;
        plan = plan_q.pop_front();
        n = sjis_to_euc(up_word.in_byte, up_word.end_of_text, conv);
        if (plan.typed) begin
          n = plan.count;
          conv = {plan.r3, plan.r2, plan.r1, plan.r0};
        end
        for (int i = 0; i < n; i++) begin
          want.out_byte  = conv[i];
          want.run_last  = (i == n - 1);
          want.text_done = (i == n - 1) && up_word.end_of_text;
          euc_expected.push_back(want);
        end
      end
      if (up_valid && up_stall) stalled_input <= stalled_input + 1;
    end
  end

  // receiver: random stalls, one long hold-off, a quiet window
  initial begin : receiver
    int hold_left;
    bit held_once;
    hold_left = 0;
    held_once = 1'b0;
    dn_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_once && items_in >= HOLD_AT) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        dn_stall <= 1'b1;
      end else begin
        dn_stall <= !calm && ($urandom_range(0, 99) < 9);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    rst      <= 1'b1;
    up_valid <= 1'b0;
    up_word  <= '0;

    // in_byte, eot, typed, count, output bytes
    dir_rows = '{
      '{8'h00, 1'b0, 1'b1, 3'd1, 8'h00, 8'h00, 8'h00, 8'h00},      // ascii low end
      '{8'h7f, 1'b0, 1'b1, 3'd1, 8'h7f, 8'h00, 8'h00, 8'h00},      // ascii high end
      '{8'h80, 1'b0, 1'b1, 3'd2, SS2_CODE, 8'h80, 8'h00, 8'h00},   // escaped bytes
      '{8'hff, 1'b0, 1'b1, 3'd2, SS2_CODE, 8'hff, 8'h00, 8'h00},
      '{8'ha0, 1'b0, 1'b1, 3'd2, SS2_CODE, 8'ha0, 8'h00, 8'h00},
      '{8'hf0, 1'b0, 1'b1, 3'd2, SS2_CODE, 8'hf0, 8'h00, 8'h00},
      '{8'h81, 1'b0, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},      // lowest lead, lowest trail
      '{8'h40, 1'b0, 1'b1, 3'd2, 8'ha1, 8'ha1, 8'h00, 8'h00},
      '{8'h9f, 1'b0, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},      // top of first range, top trail
      '{8'hfc, 1'b0, 1'b1, 3'd2, 8'hde, 8'hfe, 8'h00, 8'h00},
      '{8'he0, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},      // 0x7f trail on second range
      '{8'h7f, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hef, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},      // trail just past the gap
      '{8'h80, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h85, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},      // top low trail
      '{8'h9e, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h90, 1'b0, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},      // trail below range
      '{8'h3f, 1'b0, 1'b1, 3'd4, SS2_CODE, 8'h90, SS2_CODE, 8'h3f},
      '{8'he5, 1'b0, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},      // trail above range, text end
      '{8'hfd, 1'b1, 1'b1, 3'd4, SS2_CODE, 8'he5, SS2_CODE, 8'hfd},
      '{8'h88, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},      // lead taken as trail
      '{8'h88, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h41, 1'b1, 1'b1, 3'd1, 8'h41, 8'h00, 8'h00, 8'h00},      // ascii ends the text
      '{8'hef, 1'b1, 1'b1, 3'd2, SS2_CODE, 8'hef, 8'h00, 8'h00},   // lead ends the text
      '{8'h9a, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},      // pair ends the text
      '{8'ha0, 1'b1, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    foreach (dir_rows[i]) stim.push_back(dir_rows[i]);

    // random text, mostly well-formed
    while (stim.size() < NUM_DIRECTED + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        queue_byte(8'($urandom_range(0, 8'h7f)));
      end else if (pick < 70) begin
        queue_byte(any_lead());
        queue_byte(8'($urandom_range(TRAIL_LO, TRAIL_HI)));
      end else if (pick < 80) begin
        queue_byte(any_lead());
        if ($urandom_range(0, 1) == 0) queue_byte(8'($urandom_range(0, TRAIL_LO - 1)));
        else queue_byte(8'($urandom_range(TRAIL_HI + 1, 8'hff)));
      end else if (pick < 93) begin
        queue_byte(8'($urandom_range(0, 8'hff)));
      end else begin
        queue_byte(8'($urandom_range(8'ha0, 8'hdf)));
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (stim[k]) begin
      if (k == NUM_DIRECTED || k == DRAIN_MID) wait_for_drain();
      send_word(stim[k]);
    end
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (euc_expected.size() != 0)
      log_fail($sformatf("%0d expected words never came out", euc_expected.size()));

    $display("covered %0d shift-jis bytes (%0d text ends), %0d euc-jp words checked",
             items_in, text_ends, words_out);
    $display("input held back for %0d cycles, %0d failures", stalled_input, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
